// File: rtl/core/acms_pkg.sv
// Shared types and constants of the aggregate count-min sketch.
package acms_pkg;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int ROWS_CFG_W = 5;
    localparam int COLS_CFG_W = 11;
    localparam int ROW_IDX_W = 4;
    localparam int COL_IDX_W = 10;
    localparam int BIT_IDX_W = 5;
    localparam int HASH_W    = 32;
    localparam int STEP_W    = $clog2(HASH_W);
    localparam int APB_AW    = 3;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    localparam logic [1:0] OP_SEED   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 5'd4;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 11'd1024;

    typedef struct packed {
        logic [1:0]           operation;
        logic [KEY_W-1:0]     key;
        logic [VAL_W-1:0]     value;
        logic [ROW_IDX_W-1:0] row_index;
        logic [COL_IDX_W-1:0] column_index;
        logic [BIT_IDX_W-1:0] bit_index;
        logic [31:0]          seed_word;
    } in_t;

    // One cell of the sketch; also the result of a read.
    typedef struct packed {
        logic [31:0] cell_count;
        logic [31:0] cell_sum;
        logic [31:0] cell_min;
        logic [31:0] cell_max;
    } out_t;

    localparam out_t CELL_EMPTY = '{32'd0, 32'd0, ALL_ONES, 32'd0};

    typedef struct packed {
        logic valid;
        logic update;
    } cell_req_t;

    typedef struct packed {
        logic clearing;
        logic done;
    } cell_rsp_t;

endpackage

// File: rtl/core/acms_hash.sv
// H3 hash unit: seed word memory and a one-bit-per-cycle XOR accumulator.
module acms_hash #(
    parameter int MAX_ROWS = 16,
    parameter int KEY_BITS = 32,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [ROW_W-1:0]                row,
    input  logic [acms_pkg::KEY_W-1:0]      key,
    input  logic                            wr_en,
    input  logic [acms_pkg::ROW_IDX_W-1:0]  wr_row,
    input  logic [acms_pkg::BIT_IDX_W-1:0]  wr_bit,
    input  logic [31:0]                     wr_data,
    output logic                            done,
    output logic [acms_pkg::HASH_W-1:0]     hash
);

    localparam int HASH_BITS  = (KEY_BITS < acms_pkg::KEY_W) ? KEY_BITS : acms_pkg::KEY_W;
    localparam int BIT_W      = $clog2(HASH_BITS);
    localparam int SEED_DEPTH = MAX_ROWS * KEY_BITS;
    localparam int SEED_AW    = $clog2(SEED_DEPTH);

    logic [31:0] seed_mem [SEED_DEPTH];
    logic [31:0] seed_q;

    logic                        running_reg;
    logic [BIT_W-1:0]            bit_reg;
    logic [acms_pkg::KEY_W-1:0]  key_sh_reg;
    logic                        take_reg;
    logic                        pend_reg;
    logic                        last_reg;
    logic [acms_pkg::HASH_W-1:0] acc_reg;
    logic                        done_reg;

    logic [SEED_AW-1:0] rd_addr;
    logic [SEED_AW-1:0] wr_addr;
    logic               last_bit;

    assign rd_addr  = SEED_AW'(row) * SEED_AW'(KEY_BITS) + SEED_AW'(bit_reg);
    assign wr_addr  = SEED_AW'(wr_row) * SEED_AW'(KEY_BITS) + SEED_AW'(wr_bit);
    assign last_bit = (bit_reg == BIT_W'(HASH_BITS - 1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            seed_mem[wr_addr] <= wr_data;
        end
        if (running_reg) begin
            seed_q <= seed_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            pend_reg    <= 1'b0;
            last_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            pend_reg <= running_reg;
            last_reg <= running_reg && last_bit;
            done_reg <= pend_reg && last_reg;
            take_reg <= key_sh_reg[0];
            if (start) begin
                running_reg <= 1'b1;
                bit_reg     <= '0;
                key_sh_reg  <= key;
                acc_reg     <= '0;
            end else begin
                if (running_reg) begin
                    bit_reg    <= bit_reg + BIT_W'(1);
                    key_sh_reg <= key_sh_reg >> 1;
                    if (last_bit) begin
                        running_reg <= 1'b0;
                    end
                end
                // seed word of the previous cycle's bit is now out of the memory
                if (pend_reg && take_reg) begin
                    acc_reg <= acc_reg ^ seed_q;
                end
            end
        end
    end

    assign done = done_reg;
    assign hash = acc_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !running_reg && !pend_reg)
        else $error("hash started while busy");

endmodule

// File: rtl/core/acms_mod.sv
// Iterative remainder unit: hash modulo column count, one dividend bit per cycle.
module acms_mod (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [acms_pkg::HASH_W-1:0]      dividend,
    input  logic [acms_pkg::COLS_CFG_W-1:0]  divisor,
    output logic                             done,
    output logic [acms_pkg::COLS_CFG_W-1:0]  rem
);

    localparam int RW = acms_pkg::COLS_CFG_W;

    logic                        busy_reg;
    logic                        done_reg;
    logic [acms_pkg::STEP_W-1:0] step_reg;
    logic [acms_pkg::HASH_W-1:0] dvd_reg;
    logic [RW-1:0]               div_reg;
    logic [RW-1:0]               rem_reg;

    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          fits;
    logic [RW-1:0] rem_step;

    assign trial    = {rem_reg, dvd_reg[acms_pkg::HASH_W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign fits     = (trial >= {1'b0, div_reg});
    assign rem_step = fits ? diff[RW-1:0] : trial[RW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                dvd_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg  <= rem_step;
                dvd_reg  <= dvd_reg << 1;
                step_reg <= step_reg + acms_pkg::STEP_W'(1);
                if (step_reg == acms_pkg::STEP_W'(acms_pkg::HASH_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/core/acms_cells.sv
// Cell memory with clearing pass after reset and a read-modify-write update path.
module acms_cells #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 1024,
    localparam int CELLS = MAX_ROWS * MAX_COLS,
    localparam int AW    = $clog2(CELLS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  acms_pkg::cell_req_t           req,
    input  logic [AW-1:0]                 addr,
    input  logic [acms_pkg::VAL_W-1:0]    value,
    output acms_pkg::cell_rsp_t           rsp,
    output acms_pkg::out_t                rd_data
);

    acms_pkg::out_t cell_mem [CELLS];
    acms_pkg::out_t cell_q;

    logic                       clr_active_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic                       stage1_reg;
    logic                       upd_reg;
    logic                       done_reg;
    logic [AW-1:0]              addr_reg;
    logic [acms_pkg::VAL_W-1:0] value_reg;

    acms_pkg::out_t merged;
    acms_pkg::out_t wdata;
    logic [AW-1:0]  waddr;
    logic           wen;

    always_comb begin
        merged            = cell_q;
        merged.cell_count = cell_q.cell_count + 32'd1;
        merged.cell_sum   = cell_q.cell_sum + value_reg;
        if (value_reg < cell_q.cell_min) begin
            merged.cell_min = value_reg;
        end
        if (value_reg > cell_q.cell_max) begin
            merged.cell_max = value_reg;
        end
    end

    always_comb begin
        if (clr_active_reg) begin
            wen   = 1'b1;
            waddr = clr_addr_reg;
            wdata = acms_pkg::CELL_EMPTY;
        end else begin
            wen   = stage1_reg && upd_reg;
            waddr = addr_reg;
            wdata = merged;
        end
    end

    always_ff @(posedge aclk) begin
        if (wen) begin
            cell_mem[waddr] <= wdata;
        end
        if (req.valid) begin
            cell_q <= cell_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            stage1_reg     <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(CELLS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            stage1_reg <= req.valid;
            done_reg   <= stage1_reg;
            if (req.valid) begin
                upd_reg   <= req.update;
                addr_reg  <= addr;
                value_reg <= value;
            end
        end
    end

    assign rsp.clearing = clr_active_reg;
    assign rsp.done     = done_reg;
    assign rd_data      = cell_q;

    a_req_free: assert property (@(posedge aclk) disable iff (!aresetn)
        req.valid |-> !clr_active_reg && !stage1_reg)
        else $error("cell request while memory busy");

endmodule

// File: rtl/core/aggregate_count_min_sketch.sv
// Aggregate count-min sketch: H3 hashed rows of count/sum/min/max cells.
//
// Input transfers on s_valid/s_ready carry one item: load a seed word, update
// with key and value, or read one cell. Only a read yields a transfer on
// m_valid/m_ready. rows_in_use and cols_in_use sit behind the APB port at
// byte addresses 0 and 4.
// An update walks the rows in use one at a time; for each row it reads one
// seed word per hashed key bit, min(KEY_BITS,32) of them, takes the hash
// modulo the column count, then reads and writes back the cell memory. A
// read passes through the cell memory and S_READ to S_RDOUT, which loads the
// output register; a row or column outside the grid goes straight to S_RDOUT.
// After reset the cell memory is cleared one cell per cycle, every cell in
// turn; s_ready stays low during that pass while APB writes are taken. Seed
// words are undefined until loaded.
// A result waits in the output register while m_ready is low; loads and
// updates are still taken meanwhile, and a further read waits for the slot.
module aggregate_count_min_sketch #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  acms_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output acms_pkg::out_t                m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acms_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROWC_W = $clog2(MAX_ROWS + 1);
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = acms_pkg::COLS_CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_MOD,
        S_CELL,
        S_READ,
        S_RDOUT
    } state_t;

    state_t state_reg;

    logic [acms_pkg::ROWS_CFG_W-1:0] cfg_rows_reg;
    logic [CW-1:0]                   cfg_cols_reg;

    logic [ROWC_W-1:0]          row_reg;
    logic [acms_pkg::KEY_W-1:0] key_reg;
    logic [acms_pkg::VAL_W-1:0] value_reg;
    logic [AW-1:0]              cell_addr_reg;
    logic                       oor_reg;
    logic                       hash_start_reg;
    logic                       mod_start_reg;
    acms_pkg::cell_req_t        cell_req_reg;
    logic                       m_valid_reg;
    acms_pkg::out_t             m_data_reg;

    logic [ROWC_W-1:0]          nrows;
    logic [CW-1:0]              ncols;
    logic [ROWC_W-1:0]          row_inc;
    logic                       accept;
    logic                       read_oor;
    logic                       seed_wr;
    logic                       cfg_wr;
    logic                       hash_done;
    logic [acms_pkg::HASH_W-1:0] hash_val;
    logic                       mod_done;
    logic [CW-1:0]              mod_rem;
    acms_pkg::cell_rsp_t        cell_rsp;
    acms_pkg::out_t             cell_rd;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_rows_reg <= acms_pkg::ROWS_RESET;
            cfg_cols_reg <= acms_pkg::COLS_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                acms_pkg::REG_ROWS: cfg_rows_reg <= pwdata[acms_pkg::ROWS_CFG_W-1:0];
                acms_pkg::REG_COLS: cfg_cols_reg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            acms_pkg::REG_ROWS: prdata = 32'(cfg_rows_reg);
            acms_pkg::REG_COLS: prdata = 32'(cfg_cols_reg);
            default:            prdata = 32'd0;
        endcase
    end

    // clamp the configured sizes into the supported range
    always_comb begin
        if (cfg_rows_reg == '0) begin
            nrows = ROWC_W'(1);
        end else if (32'(cfg_rows_reg) > 32'(MAX_ROWS)) begin
            nrows = ROWC_W'(MAX_ROWS);
        end else begin
            nrows = ROWC_W'(cfg_rows_reg);
        end
        if (cfg_cols_reg == '0) begin
            ncols = CW'(1);
        end else if (32'(cfg_cols_reg) > 32'(MAX_COLS)) begin
            ncols = CW'(MAX_COLS);
        end else begin
            ncols = cfg_cols_reg;
        end
    end

    assign s_ready  = (state_reg == S_IDLE) && !cell_rsp.clearing;
    assign accept   = s_valid && s_ready;
    assign row_inc  = row_reg + ROWC_W'(1);
    assign read_oor = (32'(s_data.row_index) >= 32'(MAX_ROWS))
                   || (32'(s_data.column_index) >= 32'(MAX_COLS));
    assign seed_wr  = accept && (s_data.operation == acms_pkg::OP_SEED)
                   && (32'(s_data.row_index) < 32'(MAX_ROWS))
                   && (32'(s_data.bit_index) < 32'(KEY_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            hash_start_reg <= 1'b0;
            mod_start_reg  <= 1'b0;
            cell_req_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            hash_start_reg <= 1'b0;
            mod_start_reg  <= 1'b0;
            cell_req_reg   <= '0;
            if (m_valid_reg && m_ready && state_reg != S_RDOUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        case (s_data.operation)
                            acms_pkg::OP_UPDATE: begin
                                key_reg        <= s_data.key;
                                value_reg      <= s_data.value;
                                row_reg        <= '0;
                                hash_start_reg <= 1'b1;
                                state_reg      <= S_HASH;
                            end
                            acms_pkg::OP_READ: begin
                                if (read_oor) begin
                                    oor_reg   <= 1'b1;
                                    state_reg <= S_RDOUT;
                                end else begin
                                    oor_reg       <= 1'b0;
                                    cell_addr_reg <= AW'(s_data.row_index) * AW'(MAX_COLS)
                                                   + AW'(s_data.column_index);
                                    cell_req_reg  <= '{valid: 1'b1, update: 1'b0};
                                    state_reg     <= S_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        mod_start_reg <= 1'b1;
                        state_reg     <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        cell_addr_reg <= AW'(row_reg) * AW'(MAX_COLS) + AW'(mod_rem);
                        cell_req_reg  <= '{valid: 1'b1, update: 1'b1};
                        state_reg     <= S_CELL;
                    end
                end
                S_CELL: begin
                    if (cell_rsp.done) begin
                        if (row_inc == nrows) begin
                            state_reg <= S_IDLE;
                        end else begin
                            row_reg        <= row_inc;
                            hash_start_reg <= 1'b1;
                            state_reg      <= S_HASH;
                        end
                    end
                end
                S_READ: begin
                    if (cell_rsp.done) begin
                        state_reg <= S_RDOUT;
                    end
                end
                S_RDOUT: begin
                    // hold until the output slot is free
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= oor_reg ? acms_pkg::CELL_EMPTY : cell_rd;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    acms_hash #(
        .MAX_ROWS(MAX_ROWS),
        .KEY_BITS(KEY_BITS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start_reg),
        .row     (row_reg[ROW_W-1:0]),
        .key     (key_reg),
        .wr_en   (seed_wr),
        .wr_row  (s_data.row_index),
        .wr_bit  (s_data.bit_index),
        .wr_data (s_data.seed_word),
        .done    (hash_done),
        .hash    (hash_val)
    );

    acms_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start_reg),
        .dividend (hash_val),
        .divisor  (ncols),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    acms_cells #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_cells (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cell_req_reg),
        .addr    (cell_addr_reg),
        .value   (value_reg),
        .rsp     (cell_rsp),
        .rd_data (cell_rd)
    );

    a_hash_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_done |-> state_reg == S_HASH)
        else $error("hash result outside hash phase");

    a_cell_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_rsp.done |-> (state_reg == S_CELL || state_reg == S_READ))
        else $error("cell response with no access pending");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HASH || state_reg == S_MOD || state_reg == S_CELL)
        |-> row_reg < nrows)
        else $error("update row beyond rows in use");

endmodule
